### design/txp_pkg.sv
// Shared types and constants for the transaction input parser.
`timescale 1ns / 1ps

package txp_pkg;

    // One byte of the serialized buffer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    // One tagged byte leaving the parser.
    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  byte_value;
        logic        record_done;
        logic        bad_bytes;
        logic [31:0] prev_index;
        logic [31:0] sequence_number;
        logic [15:0] script_length;
    } out_item_t;

    // Parse phase, one-hot.
    typedef enum logic [5:0] {
        PH_HASH   = 6'b000001,
        PH_INDEX  = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_SCRIPT = 6'b001000,
        PH_SEQ    = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // Byte role codes.
    localparam logic [2:0] KIND_HASH     = 3'd0;
    localparam logic [2:0] KIND_INDEX    = 3'd1;
    localparam logic [2:0] KIND_PREFIX   = 3'd2;
    localparam logic [2:0] KIND_SCRIPT   = 3'd3;
    localparam logic [2:0] KIND_SEQUENCE = 3'd4;
    localparam logic [2:0] KIND_IGNORED  = 3'd5;

    localparam logic [15:0] HASH_BYTES  = 16'd32;
    localparam logic [15:0] INDEX_BYTES = 16'd4;
    localparam logic [15:0] SEQ_BYTES   = 16'd4;

    // Compact-size markers.
    localparam logic [7:0] CS_MARK_16 = 8'hFD;
    localparam logic [7:0] CS_MARK_32 = 8'hFE;

    localparam logic [3:0] CS_BYTES_16 = 4'd2;
    localparam logic [3:0] CS_BYTES_32 = 4'd4;
    localparam logic [3:0] CS_BYTES_64 = 4'd8;

    localparam logic [15:0] MAX_SCRIPT_RESET = 16'd10000;

endpackage

### design/transaction_input_parser.sv
// Top level of the streaming transaction input parser.
`timescale 1ns / 1ps

// Usage:
//   in_valid / in_stall / in_data carry one buffer byte per request, with
//   end_of_buffer marking the last byte of a buffer. out_valid / out_stall /
//   out_data return one tagged byte per request: its field role, the byte
//   itself, record-done and bad-bytes flags, and the running index, sequence
//   and script-length values.
//   cfg_valid / cfg_ready / cfg_data write the maximum script length; the
//   port is always ready. Write it only while no request is in flight.
// Timing:
//   Output follows in the cycle after input. One byte is taken every cycle
//   while in_stall is low; the parse state updates in the same cycle the
//   byte is accepted and the result lands in a single output register.
// Stall:
//   When out_stall holds a pending result, in_stall rises and the input side
//   waits; a new byte is taken in the same cycle the pending result drains.
// Reset:
//   rst_n clears the parse state and the output valid flag and restores the
//   maximum script length to 10000. The parser also restarts on its own
//   after every end-of-buffer byte; the configured maximum is kept.

module transaction_input_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  txp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output txp_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    logic               in_accept;
    logic [15:0]        max_len_reg;
    logic               out_valid_reg;
    txp_pkg::out_item_t out_data_reg;
    txp_pkg::out_item_t result;

    // Hold the input while a result waits on a stalled receiver.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= txp_pkg::MAX_SCRIPT_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    txp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_item (in_data),
        .max_len (max_len_reg),
        .result  (result)
    );

    // Load a new result on accept; drop the valid once the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A completed record is always tagged on a sequence byte.
    a_done_on_seq : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.record_done |->
            out_data_reg.byte_kind == txp_pkg::KIND_SEQUENCE)
        else $error("record_done on a non-sequence byte");

    // A record cannot be both complete and bad on the same byte.
    a_done_not_bad : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.record_done && out_data_reg.bad_bytes))
        else $error("record_done and bad_bytes together");

    // An accepted byte shows up, unchanged, in the next cycle.
    a_pass_through : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg &&
            out_data_reg.byte_value == $past(in_data.data_byte))
        else $error("accepted byte not passed through");

    // bad_bytes is never reported on an ignored byte.
    a_len_err_kind : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.bad_bytes &&
            out_data_reg.byte_kind == txp_pkg::KIND_IGNORED |->
            1'b0)
        else $error("bad_bytes on an ignored byte");

endmodule

### design/txp_core.sv
// Parse state and per-byte field tagging for the transaction input parser.
`timescale 1ns / 1ps

module txp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  txp_pkg::in_item_t   in_item,
    input  logic [15:0]         max_len,
    output txp_pkg::out_item_t  result
);

    txp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_lo_reg, len_lo_next;
    logic        len_hi_reg, len_hi_next;
    logic [3:0]  remain_reg, remain_next;
    logic [31:0] index_reg, index_next;
    logic [31:0] seq_reg, seq_next;
    logic [15:0] slen_reg, slen_next;
    logic        err_reg, err_next;

    logic [7:0]  b;
    logic        eob;
    logic [15:0] count_inc;
    logic [2:0]  prefix_pos;
    logic        finish;
    logic        too_long;
    logic [2:0]  kind;
    logic        done;
    logic        bad;

    assign b          = in_item.data_byte;
    assign eob        = in_item.end_of_buffer;
    assign count_inc  = count_reg + 16'd1;
    assign prefix_pos = 3'(count_reg - 16'd1);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_lo_next = len_lo_reg;
        len_hi_next = len_hi_reg;
        remain_next = remain_reg;
        index_next  = index_reg;
        seq_next    = seq_reg;
        slen_next   = slen_reg;
        err_next    = err_reg;
        kind        = txp_pkg::KIND_IGNORED;
        done        = 1'b0;
        bad         = 1'b0;
        finish      = 1'b0;
        too_long    = 1'b0;

        case (phase_reg)
            txp_pkg::PH_HASH:
            begin
                kind       = txp_pkg::KIND_HASH;
                count_next = count_inc;
                if (count_inc >= txp_pkg::HASH_BYTES)
                begin
                    phase_next = txp_pkg::PH_INDEX;
                    count_next = '0;
                end
            end
            txp_pkg::PH_INDEX:
            begin
                kind = txp_pkg::KIND_INDEX;
                case (count_reg[1:0])
                    2'd0:    index_next[7:0]   = index_reg[7:0]   | b;
                    2'd1:    index_next[15:8]  = index_reg[15:8]  | b;
                    2'd2:    index_next[23:16] = index_reg[23:16] | b;
                    default: index_next[31:24] = index_reg[31:24] | b;
                endcase
                count_next = count_inc;
                if (count_inc >= txp_pkg::INDEX_BYTES)
                begin
                    phase_next  = txp_pkg::PH_PREFIX;
                    count_next  = '0;
                    remain_next = '0;
                    len_lo_next = '0;
                    len_hi_next = 1'b0;
                end
            end
            txp_pkg::PH_PREFIX:
            begin
                kind = txp_pkg::KIND_PREFIX;
                if (count_reg == '0)
                begin
                    count_next = 16'd1;
                    if (b < txp_pkg::CS_MARK_16)
                    begin
                        len_lo_next = {8'd0, b};
                        len_hi_next = 1'b0;
                        finish      = 1'b1;
                    end
                    else
                    begin
                        if (b == txp_pkg::CS_MARK_16)
                            remain_next = txp_pkg::CS_BYTES_16;
                        else if (b == txp_pkg::CS_MARK_32)
                            remain_next = txp_pkg::CS_BYTES_32;
                        else
                            remain_next = txp_pkg::CS_BYTES_64;
                        len_lo_next = '0;
                        len_hi_next = 1'b0;
                    end
                end
                else
                begin
                    // Bytes above the low two only matter as "nonzero".
                    case (prefix_pos)
                        3'd0:    len_lo_next[7:0]  = len_lo_reg[7:0]  | b;
                        3'd1:    len_lo_next[15:8] = len_lo_reg[15:8] | b;
                        default: len_hi_next       = len_hi_reg | (b != 8'd0);
                    endcase
                    count_next = count_inc;
                    if (remain_reg != '0)
                        remain_next = remain_reg - 4'd1;
                    if (remain_next == '0)
                        finish = 1'b1;
                end

                if (finish)
                begin
                    slen_next  = len_hi_next ? 16'hFFFF : len_lo_next;
                    count_next = '0;
                    too_long   = len_hi_next || (len_lo_next > max_len);
                    if (too_long)
                    begin
                        err_next   = 1'b1;
                        phase_next = txp_pkg::PH_DONE;
                        bad        = 1'b1;
                    end
                    else if (len_lo_next == '0)
                        phase_next = txp_pkg::PH_SEQ;
                    else
                        phase_next = txp_pkg::PH_SCRIPT;
                end
            end
            txp_pkg::PH_SCRIPT:
            begin
                kind       = txp_pkg::KIND_SCRIPT;
                count_next = count_inc;
                if (count_inc >= slen_reg)
                begin
                    phase_next = txp_pkg::PH_SEQ;
                    count_next = '0;
                end
            end
            txp_pkg::PH_SEQ:
            begin
                kind = txp_pkg::KIND_SEQUENCE;
                case (count_reg[1:0])
                    2'd0:    seq_next[7:0]   = seq_reg[7:0]   | b;
                    2'd1:    seq_next[15:8]  = seq_reg[15:8]  | b;
                    2'd2:    seq_next[23:16] = seq_reg[23:16] | b;
                    default: seq_next[31:24] = seq_reg[31:24] | b;
                endcase
                count_next = count_inc;
                if (count_inc >= txp_pkg::SEQ_BYTES)
                begin
                    done       = 1'b1;
                    phase_next = txp_pkg::PH_DONE;
                    count_next = '0;
                end
            end
            default:
            begin
                kind = txp_pkg::KIND_IGNORED;
            end
        endcase

        // Early end of buffer: flag once, unless already flagged or complete.
        if (eob && (phase_next != txp_pkg::PH_DONE) && !err_next)
            bad = 1'b1;
    end

    assign result.byte_kind       = kind;
    assign result.byte_value      = b;
    assign result.record_done     = done;
    assign result.bad_bytes       = bad;
    assign result.prev_index      = index_next;
    assign result.sequence_number = seq_next;
    assign result.script_length   = slen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= txp_pkg::PH_HASH;
            count_reg  <= '0;
            len_lo_reg <= '0;
            len_hi_reg <= 1'b0;
            remain_reg <= '0;
            index_reg  <= '0;
            seq_reg    <= '0;
            slen_reg   <= '0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (eob)
            begin
                phase_reg  <= txp_pkg::PH_HASH;
                count_reg  <= '0;
                len_lo_reg <= '0;
                len_hi_reg <= 1'b0;
                remain_reg <= '0;
                index_reg  <= '0;
                seq_reg    <= '0;
                slen_reg   <= '0;
                err_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                len_lo_reg <= len_lo_next;
                len_hi_reg <= len_hi_next;
                remain_reg <= remain_next;
                index_reg  <= index_next;
                seq_reg    <= seq_next;
                slen_reg   <= slen_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule
